// File: rtl/core/rrts_pkg.sv
// shared types and constants of the round-robin thread scheduler
`default_nettype none
package rrts_pkg;

  localparam int unsigned OpW  = 3;
  localparam int unsigned TidW = 4;
  localparam int unsigned ErrW = 3;
  localparam int unsigned CntW = 5;

  typedef enum logic [OpW-1:0] {
    OP_ADD   = 3'd0,
    OP_WAKE  = 3'd1,
    OP_SLEEP = 3'd2,
    OP_BLOCK = 3'd3,
    OP_KILL  = 3'd4,
    OP_YIELD = 3'd5
  } op_e;

  typedef enum logic [ErrW-1:0] {
    ERR_OK        = 3'd0,
    ERR_ADD_STATE = 3'd1,
    ERR_WAKE_RUN  = 3'd2,
    ERR_NOT_RUN   = 3'd3,
    ERR_Q_EMPTY   = 3'd4
  } err_e;

  typedef enum logic [1:0] {
    ST_NEW      = 2'd0,
    ST_RUNNABLE = 2'd1,
    ST_BLOCKED  = 2'd2,
    ST_SLEEPING = 2'd3
  } status_e;

endpackage
`default_nettype wire

// File: rtl/core/rrts_mem.sv
// per-thread memory: status, queued flag and both links, one read port and one write port
`default_nettype none
module rrts_mem #(
  parameter int unsigned Depth = 16,
  parameter int unsigned IdxW  = 4
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [IdxW-1:0] raddr_i,
  output logic [1:0]           rstat_o,
  output logic                 rq_o,
  output logic [IdxW-1:0]      rnext_o,
  output logic [IdxW-1:0]      rprev_o,
  input  wire logic [IdxW-1:0] waddr_i,
  input  wire logic            we_stat_i,
  input  wire logic            we_next_i,
  input  wire logic            we_prev_i,
  input  wire logic [1:0]      wstat_i,
  input  wire logic            wq_i,
  input  wire logic [IdxW-1:0] wnext_i,
  input  wire logic [IdxW-1:0] wprev_i
);
  import rrts_pkg::*;

  logic [1:0]      stat_q [Depth];
  logic            q_q    [Depth];
  logic [IdxW-1:0] next_q [Depth];
  logic [IdxW-1:0] prev_q [Depth];
  logic [Depth-1:0] vld_q;

  // status and queued flag reset through valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (we_stat_i) begin
      vld_q[waddr_i] <= 1'b1;
    end
  end

  // storage write, one enable per field group
  always_ff @(posedge clk_i) begin
    if (we_stat_i) begin
      stat_q[waddr_i] <= wstat_i;
      q_q[waddr_i]    <= wq_i;
    end
    if (we_next_i) begin
      next_q[waddr_i] <= wnext_i;
    end
    if (we_prev_i) begin
      prev_q[waddr_i] <= wprev_i;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    rstat_o <= vld_q[raddr_i] ? stat_q[raddr_i] : ST_NEW;
    rq_o    <= vld_q[raddr_i] & q_q[raddr_i];
    rnext_o <= next_q[raddr_i];
    rprev_o <= prev_q[raddr_i];
  end
endmodule
`default_nettype wire

// File: rtl/core/round_robin_thread_scheduler.sv
// round-robin thread scheduler top level with its read-modify-write sequencer
//
// A request is taken at a rising edge with start_i high and busy_o low. busy_o
// stays high while the request works through the thread memory, and the result
// sits on the result ports for the single cycle in which done_o is high; the
// receiver cannot stall it. The named entry is read first; a request that fails
// or does nothing finishes there. The others then step through the write-back
// slots of the single write port in turn (entry, tail or previous link, next
// link), of which add, wake and yield use the first two, and a switch (yield,
// sleep, block, kill) goes on to read and pop the head. busy_o falls as done_o
// rises, so the next request can be taken at the edge that ends the result cycle.
`default_nettype none
module round_robin_thread_scheduler #(
  parameter int unsigned MAX_THREADS    = 16,
  parameter int unsigned MAIN_THREAD_ID = 0
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  output logic                            busy_o,
  input  wire logic [rrts_pkg::OpW-1:0]   operation_i,
  input  wire logic [rrts_pkg::TidW-1:0]  thread_id_i,
  output logic                            done_o,
  output logic [rrts_pkg::TidW-1:0]       active_thread_o,
  output logic                            switched_o,
  output logic [rrts_pkg::ErrW-1:0]       error_code_o,
  output logic [rrts_pkg::CntW-1:0]       runnable_count_o,
  output logic [rrts_pkg::CntW-1:0]       blocked_count_o,
  output logic [rrts_pkg::CntW-1:0]       sleeping_count_o,
  output logic [rrts_pkg::CntW-1:0]       total_threads_o
);
  import rrts_pkg::*;

  localparam int unsigned IdW   = TidW;
  localparam int unsigned Depth = 1 << IdW;
  localparam logic [IdW-1:0] MainId = IdW'(MAIN_THREAD_ID);

  typedef enum logic [2:0] {
    S_IDLE, S_EVAL, S_WR_T, S_WR_A, S_WR_B, S_RD_H, S_POP
  } state_e;

  state_e          state_q;
  logic [OpW-1:0]  op_q;
  logic [IdW-1:0]  tgt_q;
  logic [IdW-1:0]  head_q, tail_q, run_q;
  logic [CntW-1:0] qlen_q, nrun_q, nblk_q, nslp_q, ntot_q;

  // planned write-backs
  status_e         pl_stat_q;
  logic            pl_q_q;
  logic            pl_pvwe_q;
  logic [IdW-1:0]  pl_pv_q;
  logic            a_en_q, b_en_q;
  logic [IdW-1:0]  a_addr_q, a_val_q, b_addr_q, b_val_q;

  // memory ports
  logic [IdW-1:0]  raddr, waddr;
  logic [1:0]      m_st_raw;
  status_e         m_st;
  logic            m_q;
  logic [IdW-1:0]  m_nx, m_pv;
  logic            we_stat, we_next, we_prev;
  logic [1:0]      wstat;
  logic            wq;
  logic [IdW-1:0]  wnext, wprev;

  // request evaluation
  logic            tid_ok, is_wake, is_rm, is_yld, ev_noop, ev_app;
  err_e            ev_err;
  status_e         ev_stat;

  assign m_st = status_e'(m_st_raw);

  // read address: the target at acceptance, the head otherwise
  always_comb begin
    raddr = head_q;
    if (state_q == S_IDLE) begin
      raddr = (operation_i == OP_YIELD) ? run_q : thread_id_i;
    end
  end

  // write port, one slot per state
  always_comb begin
    waddr   = tgt_q;
    we_stat = 1'b0;
    we_next = 1'b0;
    we_prev = 1'b0;
    wstat   = pl_stat_q;
    wq      = pl_q_q;
    wnext   = a_val_q;
    wprev   = pl_pv_q;
    unique case (state_q)
      S_WR_T: begin
        we_stat = 1'b1;
        we_prev = pl_pvwe_q;
      end
      S_WR_A: begin
        waddr   = a_addr_q;
        we_next = a_en_q;
      end
      S_WR_B: begin
        waddr   = b_addr_q;
        we_prev = b_en_q;
        wprev   = b_val_q;
      end
      S_POP: begin
        waddr   = head_q;
        we_stat = 1'b1;
        wstat   = ST_RUNNABLE;
        wq      = 1'b0;
      end
      default: begin
      end
    endcase
  end

  rrts_mem #(.Depth(Depth), .IdxW(IdW)) u_mem (
    .clk_i, .rst_ni,
    .raddr_i(raddr),
    .rstat_o(m_st_raw), .rq_o(m_q), .rnext_o(m_nx), .rprev_o(m_pv),
    .waddr_i(waddr),
    .we_stat_i(we_stat), .we_next_i(we_next), .we_prev_i(we_prev),
    .wstat_i(wstat), .wq_i(wq), .wnext_i(wnext), .wprev_i(wprev)
  );

  // error and action decision from the target entry
  always_comb begin
    tid_ok  = (32'(tgt_q) < MAX_THREADS);
    is_wake = (op_q == OP_ADD) || (op_q == OP_WAKE);
    is_rm   = (op_q == OP_SLEEP) || (op_q == OP_BLOCK) || (op_q == OP_KILL);
    is_yld  = (op_q == OP_YIELD);
    ev_err  = ERR_OK;
    ev_noop = 1'b1;
    ev_app  = 1'b0;
    ev_stat = ST_RUNNABLE;
    if (is_yld) begin
      if (m_st != ST_RUNNABLE) begin
        ev_err = ERR_NOT_RUN;
      end else begin
        ev_noop = 1'b0;
        ev_app  = !m_q;
      end
    end else if (tid_ok && is_wake) begin
      if (op_q == OP_ADD && m_st != ST_NEW) begin
        ev_err = ERR_ADD_STATE;
      end else if (m_st == ST_RUNNABLE) begin
        ev_err = ERR_WAKE_RUN;
      end else begin
        ev_noop = 1'b0;
        ev_app  = !m_q && !(m_st == ST_NEW && tgt_q == MainId);
      end
    end else if (tid_ok && is_rm) begin
      if (m_st != ST_RUNNABLE) begin
        ev_err = ERR_NOT_RUN;
      end else if (qlen_q == CntW'(m_q)) begin
        ev_err = ERR_Q_EMPTY;
      end else begin
        ev_noop = 1'b0;
        ev_stat = (op_q == OP_SLEEP) ? ST_SLEEPING :
                  (op_q == OP_BLOCK) ? ST_BLOCKED : ST_NEW;
      end
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q <= '0; tgt_q <= '0;
      head_q <= '0; tail_q <= '0; qlen_q <= '0; run_q <= MainId;
      nrun_q <= '0; nblk_q <= '0; nslp_q <= '0; ntot_q <= '0;
      pl_stat_q <= ST_NEW; pl_q_q <= 1'b0; pl_pvwe_q <= 1'b0; pl_pv_q <= '0;
      a_en_q <= 1'b0; a_addr_q <= '0; a_val_q <= '0;
      b_en_q <= 1'b0; b_addr_q <= '0; b_val_q <= '0;
      done_o <= 1'b0; switched_o <= 1'b0; error_code_o <= ERR_OK;
    end else begin
      done_o <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            op_q    <= operation_i;
            tgt_q   <= raddr;
            state_q <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (ev_noop) begin
            done_o       <= 1'b1;
            switched_o   <= 1'b0;
            error_code_o <= ev_err;
            state_q      <= S_IDLE;
          end else begin
            // target entry, then tail or previous link, then next link
            pl_stat_q <= ev_stat;
            pl_q_q    <= ev_app | (m_q & ~is_rm);
            pl_pvwe_q <= ev_app & (qlen_q != '0);
            pl_pv_q   <= tail_q;
            a_en_q    <= is_rm ? (m_q & (head_q != tgt_q)) : (ev_app & (qlen_q != '0));
            a_addr_q  <= is_rm ? m_pv : tail_q;
            a_val_q   <= is_rm ? m_nx : tgt_q;
            b_en_q    <= m_q & (tail_q != tgt_q);
            b_addr_q  <= m_nx;
            b_val_q   <= m_pv;
            // queue ends and length before the switch
            if (ev_app) begin
              if (qlen_q == '0) begin
                head_q <= tgt_q;
              end
              tail_q <= tgt_q;
              qlen_q <= qlen_q + CntW'(1);
            end else if (is_rm && m_q) begin
              if (head_q == tgt_q) begin
                head_q <= m_nx;
              end
              if (tail_q == tgt_q) begin
                tail_q <= m_pv;
              end
              qlen_q <= qlen_q - CntW'(1);
            end
            // thread counters
            if (is_wake) begin
              nrun_q <= nrun_q + CntW'(1);
              case (m_st)
                ST_BLOCKED:  nblk_q <= nblk_q - CntW'(1);
                ST_SLEEPING: nslp_q <= nslp_q - CntW'(1);
                default:     ntot_q <= ntot_q + CntW'(1);
              endcase
            end else if (is_rm) begin
              nrun_q <= nrun_q - CntW'(1);
              case (ev_stat)
                ST_BLOCKED:  nblk_q <= nblk_q + CntW'(1);
                ST_SLEEPING: nslp_q <= nslp_q + CntW'(1);
                default:     ntot_q <= ntot_q - CntW'(1);
              endcase
            end
            state_q <= S_WR_T;
          end
        end
        S_WR_T: begin
          state_q <= S_WR_A;
        end
        S_WR_A: begin
          if (is_rm) begin
            state_q <= S_WR_B;
          end else if (is_yld) begin
            state_q <= S_RD_H;
          end else begin
            done_o       <= 1'b1;
            switched_o   <= 1'b0;
            error_code_o <= ERR_OK;
            state_q      <= S_IDLE;
          end
        end
        S_WR_B: begin
          state_q <= S_RD_H;
        end
        S_RD_H: begin
          state_q <= S_POP;
        end
        S_POP: begin
          // pop the head and run it
          if (qlen_q != CntW'(1)) begin
            head_q <= m_nx;
          end
          qlen_q       <= qlen_q - CntW'(1);
          run_q        <= head_q;
          done_o       <= 1'b1;
          switched_o   <= (head_q != run_q);
          error_code_o <= ERR_OK;
          state_q      <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o           = (state_q != S_IDLE);
  assign active_thread_o  = run_q;
  assign runnable_count_o = nrun_q;
  assign blocked_count_o  = nblk_q;
  assign sleeping_count_o = nslp_q;
  assign total_threads_o  = ntot_q;
endmodule
`default_nettype wire
